@@ hdl/cidal_pkg.sv @@
`timescale 1ns / 1ps

package cidal_pkg;

  localparam int MAX_ENTRIES   = 64;
  localparam int ID_W          = 32;
  localparam int OPCODE_W      = 2;
  localparam int STATUS_W      = 2;
  localparam int FOUND_INDEX_W = 6;
  localparam int ENTRY_COUNT_W = 7;
  localparam int ADDR_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
  localparam int BYTE0_LSB     = 24;

  localparam int IN_FIELDS_W   = OPCODE_W + ID_W;
  localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = STATUS_W + 1 + FOUND_INDEX_W + 1 + ENTRY_COUNT_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_ABSENT    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_EXEC,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

@@ hdl/card_id_access_list.sv @@
`timescale 1ns / 1ps
// A lookup or add reads the table one entry at a time from index 0 until it hits or
//   reaches the end of the list; an empty list needs no read.
// A delete that hits moves the later entries down, one read/write per cycle.
// Only one request is handled at a time.
// Reset: synchronous on rst; count, master ID and handshake state clear, table is unset.
module card_id_access_list
  import cidal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  master_id_we,
  input  logic [ID_W-1:0]       master_id_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] opcode, [33:2] card_id, upper bits zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] status, [2] found, [8:3] found_index, [9] is_master, [16:10] entry_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [ID_W-1:0] id_table [MAX_ENTRIES];
  logic [ID_W-1:0] mem_q;
  logic            mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic            mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [ID_W-1:0] mem_wd;

  state_t            state, state_next;
  logic [ID_W-1:0]   master_id;
  logic [CNT_W-1:0]  count;
  opcode_t           op;
  logic [ID_W-1:0]   id;
  logic [CNT_W-1:0]  issue_idx;
  logic [ADDR_W-1:0] cmp_idx;
  logic              rd_valid;
  logic              hit;
  logic [ADDR_W-1:0] pos;
  status_t           status;

  logic in_acc, out_free, issue_ok, match, id_valid, room;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign issue_ok = issue_idx < count;
  assign id_valid = id[ID_W-1:BYTE0_LSB] != '0;
  assign match    = rd_valid && id_valid && (mem_q == id);
  assign room     = count < CNT_W'(MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (mem_we) id_table[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= id_table[mem_ra];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_acc) state_next = S_SEARCH;
      S_SEARCH: if (match || (!issue_ok && !rd_valid)) state_next = S_EXEC;
      S_EXEC:   state_next = (op == OP_DELETE && hit) ? S_SHIFT : S_DONE;
      S_SHIFT:  if (!issue_ok && !rd_valid) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state == S_IDLE;
    mem_re = 1'b0;
    mem_ra = issue_idx[ADDR_W-1:0];
    mem_we = 1'b0;
    mem_wa = cmp_idx - ADDR_W'(1);
    mem_wd = mem_q;
    case (state)
      S_SEARCH: mem_re = !match && issue_ok;
      S_SHIFT: begin
        mem_re = issue_ok;
        mem_we = rd_valid;
      end
      S_EXEC: begin
        // append at the end of the list
        mem_wa = count[ADDR_W-1:0];
        mem_wd = id;
        mem_we = op == OP_ADD && !hit && room;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      master_id     <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
      rd_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (master_id_we) master_id <= master_id_wdata;
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op        <= opcode_t'(s_axis_tdata[OPCODE_W-1:0]);
            id        <= s_axis_tdata[OPCODE_W +: ID_W];
            issue_idx <= '0;
            rd_valid  <= 1'b0;
            hit       <= 1'b0;
            pos       <= '0;
          end
        end
        S_SEARCH, S_SHIFT: begin
          if (state == S_SEARCH && match) begin
            hit      <= 1'b1;
            pos      <= cmp_idx;
            rd_valid <= 1'b0;
          end else if (issue_ok) begin
            cmp_idx   <= issue_idx[ADDR_W-1:0];
            issue_idx <= issue_idx + CNT_W'(1);
            rd_valid  <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
            if (state == S_SHIFT && !rd_valid) count <= count - CNT_W'(1);
          end
        end
        S_EXEC: begin
          if (op == OP_ADD && hit) status <= ST_DUPLICATE;
          else if (op == OP_ADD && !room) status <= ST_FULL;
          else if (op == OP_DELETE && !hit) status <= ST_ABSENT;
          else status <= ST_OK;
          if (op == OP_ADD && !hit && room) count <= count + CNT_W'(1);
          if (op == OP_DELETE) begin
            // move entries above the hit down by one
            issue_idx <= CNT_W'(pos) + CNT_W'(1);
            rd_valid  <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_DATA_W'({
              ENTRY_COUNT_W'(count),
              id_valid && (id == master_id),
              FOUND_INDEX_W'(pos),
              hit,
              status});
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/cidal_check.sv @@
`timescale 1ns / 1ps
module cidal_check
  import cidal_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0]      st;
  logic                     fnd;
  logic [FOUND_INDEX_W-1:0] fidx;
  logic [ENTRY_COUNT_W-1:0] ecnt;

  assign st   = m_axis_tdata[STATUS_W-1:0];
  assign fnd  = m_axis_tdata[STATUS_W];
  assign fidx = m_axis_tdata[STATUS_W+1 +: FOUND_INDEX_W];
  assign ecnt = m_axis_tdata[STATUS_W+2+FOUND_INDEX_W +: ENTRY_COUNT_W];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_status_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (st == ST_DUPLICATE) |-> fnd)
    else $error("duplicate without hit");

  a_absent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (st == ST_ABSENT || st == ST_FULL) |-> !fnd && fidx == '0)
    else $error("absent or full with hit");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ecnt <= ENTRY_COUNT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

endmodule

bind card_id_access_list cidal_check u_cidal_check (.*);
